### design/lav_pkg.sv
package lav_pkg;

  // Fraction bits of a unit axis component.
  localparam int DIR_FRAC_BITS = 14;

  // Magnitude width that the normalizer brings each vector down to.
  localparam int UW = 16;

  // The quotient u^2 * 2^(2F+2) / s lies in [0, 2^(2F+2)], one bit per divider step.
  localparam int DIV_STEPS = 2 * DIR_FRAC_BITS + 3;

  // Square root of that quotient, two radicand bits per step.
  localparam int SQRT_STEPS = (DIV_STEPS + 1) / 2;

  // Normalizer: magnitude, scale, square, sum, divider, square root, round.
  localparam int NORM_LAT  = 4 + DIV_STEPS + SQRT_STEPS + 1;
  localparam int CROSS_LAT = 2;
  localparam int SHIFT_LAT = 3;
  localparam int BACK_LAT  = 3 * NORM_LAT + 2 * CROSS_LAT + SHIFT_LAT;

  typedef logic signed [16:0] neg_dir_t;
  typedef logic signed [15:0] dir_t;
  typedef logic signed [31:0] pos_t;
  typedef logic signed [15:0] axis_t;
  typedef logic signed [33:0] shift_t;

  // One camera after the front end: directions already negated.
  typedef struct packed {
    neg_dir_t nvd_x;
    neg_dir_t nvd_y;
    neg_dir_t nvd_z;
    neg_dir_t nb_x;
    neg_dir_t nb_y;
    neg_dir_t nb_z;
    pos_t     c_x;
    pos_t     c_y;
    pos_t     c_z;
  } cam_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

### design/lav_front.sv
module lav_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  lav_pkg::dir_t     in_view_dir_x,
  input  lav_pkg::dir_t     in_view_dir_y,
  input  lav_pkg::dir_t     in_view_dir_z,
  input  lav_pkg::dir_t     in_down_x,
  input  lav_pkg::dir_t     in_down_y,
  input  lav_pkg::dir_t     in_down_z,
  input  lav_pkg::pos_t     in_centre_x,
  input  lav_pkg::pos_t     in_centre_y,
  input  lav_pkg::pos_t     in_centre_z,
  input  lav_pkg::q_stat_t  q_stat,
  output logic              push,
  output lav_pkg::cam_t     push_item
);

  logic          fr_valid_r;
  logic          fr_valid_nxt;
  lav_pkg::cam_t fr_r;
  logic          accept;

  assign in_stall  = fr_valid_r && q_stat.full;
  assign accept    = in_valid && !in_stall;
  assign push      = fr_valid_r && !q_stat.full;
  assign push_item = fr_r;

  always_comb begin
    fr_valid_nxt = fr_valid_r;
    if (accept) begin
      fr_valid_nxt = 1'b1;
    end else if (push) begin
      fr_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else begin
      fr_valid_r <= fr_valid_nxt;
    end
  end

  // The full-scale negative input negates to +32768, which the 17-bit form holds.
  always_ff @(posedge clk) begin
    if (accept) begin
      fr_r.nvd_x <= -(17'(in_view_dir_x));
      fr_r.nvd_y <= -(17'(in_view_dir_y));
      fr_r.nvd_z <= -(17'(in_view_dir_z));
      fr_r.nb_x  <= -(17'(in_down_x));
      fr_r.nb_y  <= -(17'(in_down_y));
      fr_r.nb_z  <= -(17'(in_down_z));
      fr_r.c_x   <= in_centre_x;
      fr_r.c_y   <= in_centre_y;
      fr_r.c_z   <= in_centre_z;
    end
  end

endmodule

### design/lav_queue.sv
module lav_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  lav_pkg::cam_t    push_item,
  input  logic             pop,
  output lav_pkg::cam_t    head,
  output lav_pkg::q_stat_t q_stat
);

  lav_pkg::cam_t mem_r [2];
  logic          wp_r;
  logic          rp_r;
  logic [1:0]    cnt_r;
  logic [1:0]    cnt_nxt;

  assign head         = mem_r[rp_r];
  assign q_stat.full  = (cnt_r == 2'd2);
  assign q_stat.empty = (cnt_r == 2'd0);

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_item;
    end
  end

endmodule

### design/lav_norm.sv
module lav_norm (
  input  logic           clk,
  input  logic           en,
  input  lav_pkg::pos_t  vec_in  [3],
  output lav_pkg::axis_t vec_out [3]
);

  localparam int UW = lav_pkg::UW;
  localparam int QW = lav_pkg::DIV_STEPS;
  localparam int SW = 2 * UW + 2;
  localparam int NS = lav_pkg::SQRT_STEPS;
  localparam int RW = 2 * NS;
  localparam int KW = $clog2(32 - UW + 1);

  // Magnitudes and signs.
  logic [31:0] mag0_r [3];
  logic        neg0_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        neg0_r[i] <= vec_in[i][31];
        mag0_r[i] <= vec_in[i][31] ? 32'(-vec_in[i]) : 32'(vec_in[i]);
      end
    end
  end

  // Bring the largest magnitude below 2^UW, truncating all three alike.
  logic [31:0]   mx;
  logic [KW-1:0] k;
  logic [UW-1:0] u1_r [3];
  logic          neg1_r [3];

  always_comb begin
    mx = mag0_r[0];
    if (mag0_r[1] > mx) begin
      mx = mag0_r[1];
    end
    if (mag0_r[2] > mx) begin
      mx = mag0_r[2];
    end
    k = '0;
    for (int j = UW; j < 32; j++) begin
      if (mx[j]) begin
        k = KW'(j - UW + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        u1_r[i]   <= UW'(mag0_r[i] >> k);
        neg1_r[i] <= neg0_r[i];
      end
    end
  end

  logic [2*UW-1:0] sq2_r [3];
  logic            neg2_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq2_r[i]  <= u1_r[i] * u1_r[i];
        neg2_r[i] <= neg1_r[i];
      end
    end
  end

  // A zero vector gets a divisor of one so that every quotient is zero.
  logic [SW-1:0]   ssum;
  logic [SW-1:0]   s3_r;
  logic [2*UW-1:0] sq3_r [3];
  logic            neg3_r [3];

  assign ssum = SW'(sq2_r[0]) + SW'(sq2_r[1]) + SW'(sq2_r[2]);

  always_ff @(posedge clk) begin
    if (en) begin
      s3_r <= (ssum == '0) ? SW'(1) : ssum;
      for (int i = 0; i < 3; i++) begin
        sq3_r[i]  <= sq2_r[i];
        neg3_r[i] <= neg2_r[i];
      end
    end
  end

  // Restoring divider, one quotient bit per stage: u^2 * 2^(QW-1) / s.
  logic [QW-1:0] dq_r [QW][3];
  logic [SW-1:0] dr_r [QW][3];
  logic [SW-1:0] ds_r [QW];
  logic          dn_r [QW][3];

  for (genvar g = 0; g < QW; g++) begin : g_div
    if (g == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (en) begin
          ds_r[0] <= s3_r;
          for (int i = 0; i < 3; i++) begin
            dn_r[0][i] <= neg3_r[i];
            if (SW'(sq3_r[i]) >= s3_r) begin
              dq_r[0][i] <= QW'(1);
              dr_r[0][i] <= SW'(sq3_r[i]) - s3_r;
            end else begin
              dq_r[0][i] <= '0;
              dr_r[0][i] <= SW'(sq3_r[i]);
            end
          end
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (en) begin
          ds_r[g] <= ds_r[g-1];
          for (int i = 0; i < 3; i++) begin
            dn_r[g][i] <= dn_r[g-1][i];
            if ({dr_r[g-1][i], 1'b0} >= {1'b0, ds_r[g-1]}) begin
              dq_r[g][i] <= {dq_r[g-1][i][QW-2:0], 1'b1};
              dr_r[g][i] <= SW'({dr_r[g-1][i], 1'b0} - {1'b0, ds_r[g-1]});
            end else begin
              dq_r[g][i] <= {dq_r[g-1][i][QW-2:0], 1'b0};
              dr_r[g][i] <= SW'({dr_r[g-1][i], 1'b0});
            end
          end
        end
      end
    end
  end

  // Integer square root of the quotient, one root bit per stage.
  logic [RW-1:0] qf_r [NS][3];
  logic [NS-1:0] qr_r [NS][3];
  logic [NS+1:0] qm_r [NS][3];
  logic          qn_r [NS][3];

  for (genvar g = 0; g < NS; g++) begin : g_sqrt
    logic [RW-1:0] f_in    [3];
    logic [NS-1:0] root_in [3];
    logic [NS+1:0] rem_in  [3];
    logic          n_in    [3];
    logic [NS+3:0] rem2    [3];
    logic [NS+3:0] trial   [3];

    if (g == 0) begin : g_src
      always_comb begin
        for (int i = 0; i < 3; i++) begin
          f_in[i]    = RW'(dq_r[QW-1][i]);
          root_in[i] = '0;
          rem_in[i]  = '0;
          n_in[i]    = dn_r[QW-1][i];
        end
      end
    end else begin : g_src
      always_comb begin
        for (int i = 0; i < 3; i++) begin
          f_in[i]    = qf_r[g-1][i];
          root_in[i] = qr_r[g-1][i];
          rem_in[i]  = qm_r[g-1][i];
          n_in[i]    = qn_r[g-1][i];
        end
      end
    end

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        rem2[i]  = {rem_in[i], f_in[i][RW-1:RW-2]};
        trial[i] = {2'b00, root_in[i], 2'b01};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          qf_r[g][i] <= {f_in[i][RW-3:0], 2'b00};
          qn_r[g][i] <= n_in[i];
          if (rem2[i] >= trial[i]) begin
            qm_r[g][i] <= (NS+2)'(rem2[i] - trial[i]);
            qr_r[g][i] <= {root_in[i][NS-2:0], 1'b1};
          end else begin
            qm_r[g][i] <= (NS+2)'(rem2[i]);
            qr_r[g][i] <= {root_in[i][NS-2:0], 1'b0};
          end
        end
      end
    end
  end

  // Largest q with (2q-1)^2 <= quotient is (isqrt + 1) / 2.
  logic [NS:0] rnd [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rnd[i] = {1'b0, qr_r[NS-1][i]} + (NS+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (qn_r[NS-1][i]) begin
          vec_out[i] <= -$signed(16'(rnd[i][NS:1]));
        end else begin
          vec_out[i] <= $signed(16'(rnd[i][NS:1]));
        end
      end
    end
  end

endmodule

### design/lav_back.sv
module lav_back (
  input  logic             clk,
  input  logic             rst_n,
  input  lav_pkg::cam_t    head,
  input  lav_pkg::q_stat_t q_stat,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output lav_pkg::axis_t   out_right_x,
  output lav_pkg::axis_t   out_right_y,
  output lav_pkg::axis_t   out_right_z,
  output lav_pkg::axis_t   out_up_x,
  output lav_pkg::axis_t   out_up_y,
  output lav_pkg::axis_t   out_up_z,
  output lav_pkg::axis_t   out_back_x,
  output lav_pkg::axis_t   out_back_y,
  output lav_pkg::axis_t   out_back_z,
  output lav_pkg::shift_t  out_shift_0,
  output lav_pkg::shift_t  out_shift_1,
  output lav_pkg::shift_t  out_shift_2
);

  localparam int N = lav_pkg::NORM_LAT;
  localparam int L = lav_pkg::BACK_LAT;
  localparam int F = lav_pkg::DIR_FRAC_BITS;

  logic en;
  logic vd_r [L];

  // The whole back pipeline moves together unless a finished item is held.
  assign en        = !(out_valid && out_stall);
  assign pop       = en && !q_stat.empty;
  assign out_valid = vd_r[L-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int d = 0; d < L; d++) begin
        vd_r[d] <= 1'b0;
      end
    end else if (en) begin
      vd_r[0] <= !q_stat.empty;
      for (int d = 1; d < L; d++) begin
        vd_r[d] <= vd_r[d-1];
      end
    end
  end

  // Back axis.
  lav_pkg::pos_t  zin [3];
  lav_pkg::axis_t zv  [3];

  assign zin[0] = 32'(head.nvd_x);
  assign zin[1] = 32'(head.nvd_y);
  assign zin[2] = 32'(head.nvd_z);

  lav_norm u_norm_z (
    .clk     (clk),
    .en      (en),
    .vec_in  (zin),
    .vec_out (zv)
  );

  // Delay lines that keep operands in step with the normalizers.
  lav_pkg::neg_dir_t nbd_r [N][3];
  lav_pkg::pos_t     cd_r  [3*N+4][3];
  lav_pkg::axis_t    zd_r  [2*N+7][3];
  lav_pkg::axis_t    xd_r  [N+5][3];
  lav_pkg::axis_t    yd_r  [3][3];
  lav_pkg::axis_t    xv    [3];
  lav_pkg::axis_t    yv    [3];

  always_ff @(posedge clk) begin
    if (en) begin
      nbd_r[0][0] <= head.nb_x;
      nbd_r[0][1] <= head.nb_y;
      nbd_r[0][2] <= head.nb_z;
      for (int d = 1; d < N; d++) begin
        nbd_r[d] <= nbd_r[d-1];
      end
      cd_r[0][0] <= head.c_x;
      cd_r[0][1] <= head.c_y;
      cd_r[0][2] <= head.c_z;
      for (int d = 1; d < 3*N+4; d++) begin
        cd_r[d] <= cd_r[d-1];
      end
      zd_r[0] <= zv;
      for (int d = 1; d < 2*N+7; d++) begin
        zd_r[d] <= zd_r[d-1];
      end
      xd_r[0] <= xv;
      for (int d = 1; d < N+5; d++) begin
        xd_r[d] <= xd_r[d-1];
      end
      yd_r[0] <= yv;
      for (int d = 1; d < 3; d++) begin
        yd_r[d] <= yd_r[d-1];
      end
    end
  end

  // Right axis: (-down) x back.
  logic signed [32:0] c1p_r [6];
  lav_pkg::pos_t      c1t_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      c1p_r[0] <= nbd_r[N-1][1] * zv[2];
      c1p_r[1] <= nbd_r[N-1][2] * zv[1];
      c1p_r[2] <= nbd_r[N-1][2] * zv[0];
      c1p_r[3] <= nbd_r[N-1][0] * zv[2];
      c1p_r[4] <= nbd_r[N-1][0] * zv[1];
      c1p_r[5] <= nbd_r[N-1][1] * zv[0];
      c1t_r[0] <= 32'(c1p_r[0] - c1p_r[1]);
      c1t_r[1] <= 32'(c1p_r[2] - c1p_r[3]);
      c1t_r[2] <= 32'(c1p_r[4] - c1p_r[5]);
    end
  end

  lav_norm u_norm_x (
    .clk     (clk),
    .en      (en),
    .vec_in  (c1t_r),
    .vec_out (xv)
  );

  // Up axis: back x right.
  logic signed [31:0] c2p_r [6];
  lav_pkg::pos_t      c2t_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      c2p_r[0] <= zd_r[N+1][1] * xv[2];
      c2p_r[1] <= zd_r[N+1][2] * xv[1];
      c2p_r[2] <= zd_r[N+1][2] * xv[0];
      c2p_r[3] <= zd_r[N+1][0] * xv[2];
      c2p_r[4] <= zd_r[N+1][0] * xv[1];
      c2p_r[5] <= zd_r[N+1][1] * xv[0];
      c2t_r[0] <= c2p_r[0] - c2p_r[1];
      c2t_r[1] <= c2p_r[2] - c2p_r[3];
      c2t_r[2] <= c2p_r[4] - c2p_r[5];
    end
  end

  lav_norm u_norm_y (
    .clk     (clk),
    .en      (en),
    .vec_in  (c2t_r),
    .vec_out (yv)
  );

  // Translations: minus axis dot centre, rounded half up, then saturated.
  lav_pkg::axis_t     ax    [3][3];
  logic signed [47:0] ep_r  [3][3];
  logic signed [49:0] dsum  [3];
  logic signed [35:0] sq_r  [3];
  lav_pkg::shift_t    sh_r  [3];

  assign ax[0] = xd_r[N+1];
  assign ax[1] = yv;
  assign ax[2] = zd_r[2*N+3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      dsum[r] = (50'sd1 <<< (F - 1)) -
                (50'(ep_r[r][0]) + 50'(ep_r[r][1]) + 50'(ep_r[r][2]));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        for (int i = 0; i < 3; i++) begin
          ep_r[r][i] <= ax[r][i] * cd_r[3*N+3][i];
        end
        sq_r[r] <= 36'(dsum[r] >>> F);
        if (!sq_r[r][35] && (sq_r[r][34:33] != 2'b00)) begin
          sh_r[r] <= {1'b0, {33{1'b1}}};
        end else if (sq_r[r][35] && (sq_r[r][34:33] != 2'b11)) begin
          sh_r[r] <= {1'b1, {33{1'b0}}};
        end else begin
          sh_r[r] <= sq_r[r][33:0];
        end
      end
    end
  end

  assign out_right_x = xd_r[N+4][0];
  assign out_right_y = xd_r[N+4][1];
  assign out_right_z = xd_r[N+4][2];
  assign out_up_x    = yd_r[2][0];
  assign out_up_y    = yd_r[2][1];
  assign out_up_z    = yd_r[2][2];
  assign out_back_x  = zd_r[2*N+6][0];
  assign out_back_y  = zd_r[2*N+6][1];
  assign out_back_z  = zd_r[2*N+6][2];
  assign out_shift_0 = sh_r[0];
  assign out_shift_1 = sh_r[1];
  assign out_shift_2 = sh_r[2];

endmodule

### design/look_at_view_matrix.sv
// Look-at view matrix unit. One input item carries a camera view direction, an
// image-down vector (both Q2.14) and a camera centre (Q16.16). One result item
// carries the three unit axes of the view transform (right, up, back, Q2.14)
// and the three translations (Q18.16, saturated to 34 bits).
// Both channels use valid and stall; an item moves on a rising edge where
// valid is high and stall is low.
// The front end registers and negates each item and hands it to a two-entry
// queue. The back end is one pipeline of 163 stages: three normalizers of 52
// stages each (a restoring divider of one quotient bit per stage followed by
// a square root of one bit per stage), two cross-product stages before each
// of the second and third normalizers, and three stages for the translations.
// When nothing stalls, the block takes one item every cycle.
// When the receiver stalls, the whole back pipeline holds; the queue and the
// front register then fill, and in_stall rises once they hold three items.
// Reset clears the valid bits of the front register, the queue and the
// pipeline; no result is shown until an item has passed through.
module look_at_view_matrix (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  lav_pkg::dir_t   in_view_dir_x,
  input  lav_pkg::dir_t   in_view_dir_y,
  input  lav_pkg::dir_t   in_view_dir_z,
  input  lav_pkg::dir_t   in_down_x,
  input  lav_pkg::dir_t   in_down_y,
  input  lav_pkg::dir_t   in_down_z,
  input  lav_pkg::pos_t   in_centre_x,
  input  lav_pkg::pos_t   in_centre_y,
  input  lav_pkg::pos_t   in_centre_z,
  output logic            out_valid,
  input  logic            out_stall,
  output lav_pkg::axis_t  out_right_x,
  output lav_pkg::axis_t  out_right_y,
  output lav_pkg::axis_t  out_right_z,
  output lav_pkg::axis_t  out_up_x,
  output lav_pkg::axis_t  out_up_y,
  output lav_pkg::axis_t  out_up_z,
  output lav_pkg::axis_t  out_back_x,
  output lav_pkg::axis_t  out_back_y,
  output lav_pkg::axis_t  out_back_z,
  output lav_pkg::shift_t out_shift_0,
  output lav_pkg::shift_t out_shift_1,
  output lav_pkg::shift_t out_shift_2
);

  lav_pkg::q_stat_t q_stat;
  lav_pkg::cam_t    push_item;
  lav_pkg::cam_t    head;
  logic             push;
  logic             pop;

  lav_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_view_dir_x (in_view_dir_x),
    .in_view_dir_y (in_view_dir_y),
    .in_view_dir_z (in_view_dir_z),
    .in_down_x     (in_down_x),
    .in_down_y     (in_down_y),
    .in_down_z     (in_down_z),
    .in_centre_x   (in_centre_x),
    .in_centre_y   (in_centre_y),
    .in_centre_z   (in_centre_z),
    .q_stat        (q_stat),
    .push          (push),
    .push_item     (push_item)
  );

  lav_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  lav_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head        (head),
    .q_stat      (q_stat),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_right_x (out_right_x),
    .out_right_y (out_right_y),
    .out_right_z (out_right_z),
    .out_up_x    (out_up_x),
    .out_up_y    (out_up_y),
    .out_up_z    (out_up_z),
    .out_back_x  (out_back_x),
    .out_back_y  (out_back_y),
    .out_back_z  (out_back_z),
    .out_shift_0 (out_shift_0),
    .out_shift_1 (out_shift_1),
    .out_shift_2 (out_shift_2)
  );

endmodule
